@@ rtl/core/mphc_pkg.sv @@
// Shared types, codes and constants for the media packet header checker.
package mphc_pkg;

	// Header constants
	localparam logic [7:0]  HDR_VERSION    = 8'd1;
	localparam logic [31:0] MAGIC_FAV1     = 32'h4641_5631;
	localparam logic [7:0]  FLAG_CONTINUES = 8'h01;
	localparam logic [31:0] ALL_ONES_32    = 32'hFFFF_FFFF;

	// Packet type codes
	localparam logic [7:0] TYPE_HELLO   = 8'd1;
	localparam logic [7:0] TYPE_CONFIG  = 8'd2;
	localparam logic [7:0] TYPE_AUDIO   = 8'd3;
	localparam logic [7:0] TYPE_VIDEO   = 8'd4;
	localparam logic [7:0] TYPE_PALETTE = 8'd5;
	localparam logic [7:0] TYPE_END     = 8'd6;
	localparam logic [7:0] TYPE_ERROR   = 8'd7;

	// Widths
	localparam int IN_DATA_W  = 192;
	localparam int OUT_DATA_W = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Register reset values
	localparam logic [15:0] RST_CONTROL_MAX  = 16'd4096;
	localparam logic [15:0] RST_AUDIO_BYTES  = 16'd640;
	localparam logic [15:0] RST_PALETTE_BYTES = 16'd512;
	localparam logic [23:0] RST_VIDEO_MAX    = 24'd65536;
	localparam logic [9:0]  RST_AUDIO_STEP   = 10'd20;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CONTROL_MAX   = 3'd0,
		REG_AUDIO_BYTES   = 3'd1,
		REG_PALETTE_BYTES = 3'd2,
		REG_VIDEO_MAX     = 3'd3,
		REG_AUDIO_STEP    = 3'd4
	} reg_idx_t;

	// Result status codes
	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_MALFORMED = 2'd1,
		STATUS_REFUSED   = 2'd2
	} status_t;

	// One header word, magic in the lowest bits
	typedef struct packed {
		logic [31:0] payload_length;
		logic [31:0] timestamp_ms;
		logic [31:0] sequence_req;
		logic [31:0] session_id;
		logic [7:0]  flag_bits;
		logic [7:0]  reserved_high;
		logic [7:0]  packet_type;
		logic [7:0]  version;
		logic [31:0] magic;
	} hdr_t;

	// Configuration register set
	typedef struct packed {
		logic [15:0] control_max_bytes;
		logic [15:0] audio_payload_bytes;
		logic [15:0] palette_payload_bytes;
		logic [23:0] video_max_bytes;
		logic [9:0]  audio_step_ms;
	} cfg_t;

	// Stream tracking state
	typedef struct packed {
		logic        is_configured;
		logic        has_ended;
		logic [31:0] bound_session;
		logic [31:0] expected_sequence;
		logic [31:0] next_audio_time;
		logic        frame_under_way;
		logic [31:0] last_frame_time;
	} st_t;

	// One result word, status in the lowest bits
	typedef struct packed {
		logic    stream_ended;
		status_t status;
	} res_t;

endpackage

@@ rtl/core/mphc_cfg_regs.sv @@
// Configuration register file of the media packet header checker.
module mphc_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mphc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mphc_pkg::CFG_DATA_W-1:0]    cfg_data,
	output mphc_pkg::cfg_t                     cfg
);

	mphc_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.control_max_bytes     <= mphc_pkg::RST_CONTROL_MAX;
			cfg_q.audio_payload_bytes   <= mphc_pkg::RST_AUDIO_BYTES;
			cfg_q.palette_payload_bytes <= mphc_pkg::RST_PALETTE_BYTES;
			cfg_q.video_max_bytes       <= mphc_pkg::RST_VIDEO_MAX;
			cfg_q.audio_step_ms         <= mphc_pkg::RST_AUDIO_STEP;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mphc_pkg::REG_CONTROL_MAX:   cfg_q.control_max_bytes     <= cfg_data[15:0];
				mphc_pkg::REG_AUDIO_BYTES:   cfg_q.audio_payload_bytes   <= cfg_data[15:0];
				mphc_pkg::REG_PALETTE_BYTES: cfg_q.palette_payload_bytes <= cfg_data[15:0];
				mphc_pkg::REG_VIDEO_MAX:     cfg_q.video_max_bytes       <= cfg_data[23:0];
				mphc_pkg::REG_AUDIO_STEP:    cfg_q.audio_step_ms         <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/core/mphc_header_check.sv @@
// Header format check: magic, version, reserved byte, flags and length by type.
module mphc_header_check (
	input  mphc_pkg::hdr_t hdr,
	input  mphc_pkg::cfg_t cfg,
	output logic           hdr_ok
);

	logic base_ok;
	logic flags_zero;
	logic len_nonzero;
	logic ctrl_len_ok;
	logic video_len_ok;

	// Fixed fields and length compares
	assign base_ok      = (hdr.magic == mphc_pkg::MAGIC_FAV1) &&
	                      (hdr.version == mphc_pkg::HDR_VERSION) &&
	                      (hdr.reserved_high == 8'd0);
	assign flags_zero   = (hdr.flag_bits == 8'd0);
	assign len_nonzero  = (hdr.payload_length != 32'd0);
	assign ctrl_len_ok  = len_nonzero &&
	                      (hdr.payload_length <= {16'd0, cfg.control_max_bytes});
	assign video_len_ok = len_nonzero &&
	                      (hdr.payload_length <= {8'd0, cfg.video_max_bytes});

	// Per-type rules
	always_comb begin
		hdr_ok = 1'b0;
		if (base_ok) begin
			case (hdr.packet_type)
				mphc_pkg::TYPE_HELLO,
				mphc_pkg::TYPE_CONFIG,
				mphc_pkg::TYPE_ERROR:   hdr_ok = flags_zero && ctrl_len_ok;
				mphc_pkg::TYPE_END:     hdr_ok = flags_zero && !len_nonzero;
				mphc_pkg::TYPE_AUDIO:   hdr_ok = flags_zero &&
				                          (hdr.payload_length == {16'd0, cfg.audio_payload_bytes});
				mphc_pkg::TYPE_PALETTE: hdr_ok = flags_zero &&
				                          (hdr.payload_length == {16'd0, cfg.palette_payload_bytes});
				mphc_pkg::TYPE_VIDEO:   hdr_ok = ((hdr.flag_bits & ~mphc_pkg::FLAG_CONTINUES) == 8'd0)
				                          && video_len_ok;
				default:                hdr_ok = 1'b0;
			endcase
		end
	end

endmodule

@@ rtl/core/mphc_stream_rules.sv @@
// Stream rule checker: session binding, sequence, audio and video timing, end of stream.
module mphc_stream_rules (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  mphc_pkg::hdr_t hdr,
	input  logic           hdr_ok,
	input  mphc_pkg::cfg_t cfg,
	output mphc_pkg::res_t res
);

	mphc_pkg::st_t st_q;
	mphc_pkg::st_t st_nxt;
	logic          stream_ok;
	logic [32:0]   audio_sum;

	// Audio end time with carry for the overflow check
	assign audio_sum = {1'b0, hdr.timestamp_ms} + {23'd0, cfg.audio_step_ms};

	// Rule evaluation and next state
	always_comb begin
		st_nxt    = st_q;
		stream_ok = 1'b0;
		if (st_q.has_ended) begin
			stream_ok = 1'b0;
		end else if (!st_q.is_configured) begin
			if (hdr.packet_type == mphc_pkg::TYPE_CONFIG && hdr.session_id != 32'd0 &&
			    hdr.sequence_req == 32'd0 && hdr.timestamp_ms == 32'd0) begin
				stream_ok                = 1'b1;
				st_nxt.is_configured     = 1'b1;
				st_nxt.bound_session     = hdr.session_id;
				st_nxt.expected_sequence = 32'd1;
			end
		end else if (hdr.session_id == st_q.bound_session &&
		             hdr.sequence_req == st_q.expected_sequence &&
		             hdr.sequence_req != mphc_pkg::ALL_ONES_32) begin
			case (hdr.packet_type)
				mphc_pkg::TYPE_AUDIO: begin
					if (hdr.timestamp_ms == st_q.next_audio_time && !audio_sum[32]) begin
						stream_ok              = 1'b1;
						st_nxt.next_audio_time = audio_sum[31:0];
					end
				end
				mphc_pkg::TYPE_VIDEO: begin
					if ((hdr.flag_bits & mphc_pkg::FLAG_CONTINUES) != 8'd0) begin
						stream_ok = st_q.frame_under_way;
					end else if (!(st_q.frame_under_way &&
					               hdr.timestamp_ms <= st_q.last_frame_time)) begin
						stream_ok              = 1'b1;
						st_nxt.frame_under_way = 1'b1;
						st_nxt.last_frame_time = hdr.timestamp_ms;
					end
				end
				mphc_pkg::TYPE_PALETTE: begin
					stream_ok = 1'b1;
				end
				mphc_pkg::TYPE_END,
				mphc_pkg::TYPE_ERROR: begin
					stream_ok        = 1'b1;
					st_nxt.has_ended = 1'b1;
				end
				default: stream_ok = 1'b0;
			endcase
			if (stream_ok) begin
				st_nxt.expected_sequence = st_q.expected_sequence + 32'd1;
			end
		end
	end

	// Result word
	always_comb begin
		if (!hdr_ok) begin
			res.status       = mphc_pkg::STATUS_MALFORMED;
			res.stream_ended = st_q.has_ended;
		end else if (!stream_ok) begin
			res.status       = mphc_pkg::STATUS_REFUSED;
			res.stream_ended = st_q.has_ended;
		end else begin
			res.status       = mphc_pkg::STATUS_OK;
			res.stream_ended = st_nxt.has_ended;
		end
	end

	// State moves only on a word that passes both checks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (fire && hdr_ok && stream_ok) begin
			st_q <= st_nxt;
		end
	end

	// A closed stream was opened first
	a_ended_needs_config: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.has_ended |-> st_q.is_configured)
		else $error("stream ended without configuration");

	// Once closed, the stream stays closed
	a_ended_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.has_ended |=> st_q.has_ended)
		else $error("ended flag dropped");

	// Any rejected word leaves the stream state alone
	a_reject_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !(hdr_ok && stream_ok)) |=> $stable(st_q))
		else $error("rejected word changed stream state");

	// An accepted word after configuration advances the sequence by one
	a_seq_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && hdr_ok && stream_ok && st_q.is_configured)
		|=> st_q.expected_sequence == $past(st_q.expected_sequence) + 32'd1)
		else $error("sequence did not advance");

endmodule

@@ rtl/core/media_packet_header_check.sv @@
// Top level of the media packet header checker: input stage, checks and result register.
//
//  Channel   Direction  Handshake              Payload
//  s_*       in         s_tvalid / s_tready    s_tdata: one split packet header
//  m_*       out        m_tvalid / m_tready    m_tdata: status and ended flag
//  cfg_*     in         cfg_valid / cfg_ready  cfg_index, cfg_data: register write
//
//  One header per cycle sustained while the result register drains; a taken word is held
//  in the input register, passes the checks and state update, and loads the result
//  register once that register is free or being read, which raises m_tvalid.
//  arst_n clears the stream state, both stage valids and loads the register defaults.
//  A stalled result holds; the input stage still takes a word while the result
//  register is full and the input stage is empty. cfg_ready is always high.
module media_packet_header_check (
	input  logic                                clk,
	input  logic                                arst_n,
	// magic[31:0], version[39:32], packet_type[47:40], reserved_high[55:48],
	// flag_bits[63:56], session_id[95:64], sequence_req[127:96],
	// timestamp_ms[159:128], payload_length[191:160]
	input  logic [mphc_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// status[1:0], stream_ended[2], zero fill[7:3]
	output logic [mphc_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mphc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mphc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	mphc_pkg::cfg_t cfg;
	mphc_pkg::hdr_t hdr_s1;
	logic           valid_s1;
	logic           adv_s1;
	logic           hdr_ok;
	mphc_pkg::res_t res;
	mphc_pkg::res_t res_q;
	logic           out_valid_q;

	mphc_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stage flow control
	assign adv_s1   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			hdr_s1 <= mphc_pkg::hdr_t'(s_tdata);
		end
	end

	mphc_header_check u_header_check (
		.hdr    (hdr_s1),
		.cfg    (cfg),
		.hdr_ok (hdr_ok)
	);

	mphc_stream_rules u_stream_rules (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv_s1),
		.hdr    (hdr_s1),
		.hdr_ok (hdr_ok),
		.cfg    (cfg),
		.res    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(mphc_pkg::OUT_DATA_W - $bits(mphc_pkg::res_t)){1'b0}}, res_q};

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the media packet header checker.
`timescale 1ns / 1ps

module testbench;
	import mphc_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD_CYCLES = 200;
	localparam int MAX_REPORTS = 10;
	// index past the register file, writes must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	media_packet_header_check uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tdata(s_tdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata(m_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// headers waiting to be sent, verdicts waiting to come back
	hdr_t header_q[$];
	res_t verdict_q[$];

	// checker registers as the testbench believes them
	logic [15:0] lim_ctrl = RST_CONTROL_MAX;
	logic [15:0] len_audio = RST_AUDIO_BYTES;
	logic [15:0] len_palette = RST_PALETTE_BYTES;
	logic [23:0] lim_video = RST_VIDEO_MAX;
	logic [9:0] audio_step = RST_AUDIO_STEP;

	// stream tracking as the checker should hold it
	logic bound = 1'b0;
	logic closed = 1'b0;
	logic frame_open = 1'b0;
	logic [31:0] sess_bound = '0;
	logic [31:0] seq_next = '0;
	logic [31:0] audio_next = '0;
	logic [31:0] frame_ts = '0;

	// stimulus-side view of a clean stream
	logic [31:0] g_sess;
	logic [31:0] g_seq = '0;
	logic [31:0] g_audio = '0;
	logic [31:0] g_frame_ts = '0;
	logic g_frame_on = 1'b0;

	int unsigned err_cnt = 0;
	int unsigned n_words = 0;
	int unsigned n_results = 0;
	int unsigned n_writes = 0;
	int unsigned status_cnt[3] = '{0, 0, 0};
	int unsigned hold_req = 0;

	// verdict for one header; updates the tracked stream state
	function automatic res_t judge_header(hdr_t h);
		logic hdr_ok;
		status_t st;
		res_t r;
		hdr_ok = (h.magic == MAGIC_FAV1) && (h.version == HDR_VERSION) &&
			(h.reserved_high == 8'd0);
		case (h.packet_type)
			TYPE_HELLO, TYPE_CONFIG, TYPE_ERROR: hdr_ok = hdr_ok && (h.flag_bits == 8'd0) &&
				(h.payload_length != 0) && (h.payload_length <= lim_ctrl);
			TYPE_END: hdr_ok = hdr_ok && (h.flag_bits == 8'd0) && (h.payload_length == 0);
			TYPE_AUDIO: hdr_ok = hdr_ok && (h.flag_bits == 8'd0) &&
				(h.payload_length == len_audio);
			TYPE_PALETTE: hdr_ok = hdr_ok && (h.flag_bits == 8'd0) &&
				(h.payload_length == len_palette);
			TYPE_VIDEO: hdr_ok = hdr_ok && ((h.flag_bits & ~FLAG_CONTINUES) == 8'd0) &&
				(h.payload_length != 0) && (h.payload_length <= lim_video);
			default: hdr_ok = 1'b0;
		endcase

		if (!hdr_ok) begin
			st = STATUS_MALFORMED;
		end else if (closed) begin
			st = STATUS_REFUSED;
		end else if (!bound) begin
			// only a clean config packet opens the stream
			if (h.packet_type == TYPE_CONFIG && h.session_id != 0 && h.sequence_req == 0 &&
					h.timestamp_ms == 0) begin
				st = STATUS_OK;
				bound = 1'b1;
				sess_bound = h.session_id;
				seq_next = 32'd1;
			end else begin
				st = STATUS_REFUSED;
			end
		end else if (h.session_id != sess_bound || h.sequence_req != seq_next ||
				h.sequence_req == ALL_ONES_32) begin
			st = STATUS_REFUSED;
		end else begin
			st = STATUS_OK;
			case (h.packet_type)
				TYPE_AUDIO: begin
					if (h.timestamp_ms != audio_next ||
							h.timestamp_ms > ALL_ONES_32 - {22'd0, audio_step})
						st = STATUS_REFUSED;
					else
						audio_next = h.timestamp_ms + {22'd0, audio_step};
				end
				TYPE_VIDEO: begin
					if ((h.flag_bits & FLAG_CONTINUES) != 8'd0) begin
						if (!frame_open)
							st = STATUS_REFUSED;
					end else if (frame_open && h.timestamp_ms <= frame_ts) begin
						st = STATUS_REFUSED;
					end else begin
						frame_open = 1'b1;
						frame_ts = h.timestamp_ms;
					end
				end
				TYPE_PALETTE: ;
				TYPE_END, TYPE_ERROR: closed = 1'b1;
				default: st = STATUS_REFUSED;
			endcase
			if (st == STATUS_OK)
				seq_next = seq_next + 32'd1;
		end
		r.status = st;
		r.stream_ended = closed;
		return r;
	endfunction

	// header with good magic, version and reserved byte
	function automatic hdr_t mk_hdr(logic [7:0] ptype, logic [7:0] flags, logic [31:0] sess,
			logic [31:0] seq, logic [31:0] ts, logic [31:0] len);
		hdr_t h;
		h.magic = MAGIC_FAV1;
		h.version = HDR_VERSION;
		h.packet_type = ptype;
		h.reserved_high = 8'd0;
		h.flag_bits = flags;
		h.session_id = sess;
		h.sequence_req = seq;
		h.timestamp_ms = ts;
		h.payload_length = len;
		return h;
	endfunction

	// next packet of the clean stream, not yet counted as sent
	function automatic hdr_t next_legal();
		int unsigned pick;
		logic [31:0] vlen;
		pick = $urandom_range(0, 9);
		case ($urandom_range(0, 3))
			0: vlen = 32'd1;
			1: vlen = {8'd0, lim_video};
			default: vlen = $urandom_range(1, lim_video);
		endcase
		if (pick < 3)
			return mk_hdr(TYPE_AUDIO, 8'd0, g_sess, g_seq, g_audio, {16'd0, len_audio});
		if (pick < 5 || (pick < 7 && !g_frame_on))
			return mk_hdr(TYPE_VIDEO, 8'd0, g_sess, g_seq,
				g_frame_on ? g_frame_ts + $urandom_range(1, 5000) : $urandom, vlen);
		if (pick < 7)
			return mk_hdr(TYPE_VIDEO, FLAG_CONTINUES, g_sess, g_seq, $urandom, vlen);
		return mk_hdr(TYPE_PALETTE, 8'd0, g_sess, g_seq, $urandom, {16'd0, len_palette});
	endfunction

	// break one rule of a clean packet
	function automatic hdr_t corrupt(hdr_t h);
		case ($urandom_range(0, 11))
			0: h.magic = h.magic ^ (32'd1 << $urandom_range(0, 31));
			1: begin
				h.version = 8'($urandom);
				if (h.version == HDR_VERSION)
					h.version = 8'd0;
			end
			2: h.reserved_high = 8'($urandom_range(1, 255));
			3: begin
				if (h.packet_type == TYPE_VIDEO)
					h.flag_bits = h.flag_bits | (8'd1 << $urandom_range(1, 7));
				else
					h.flag_bits = 8'($urandom_range(1, 255));
			end
			4: begin
				if (h.packet_type == TYPE_VIDEO)
					h.payload_length = $urandom_range(0, 1) ? 32'd0 :
						{8'd0, lim_video} + $urandom_range(1, 32'hFF00_0000);
				else
					h.payload_length = h.payload_length + $urandom_range(1, 1000);
			end
			5: h.packet_type = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(8, 255));
			6: h.session_id = h.session_id ^ ($urandom | 32'd1);
			7: h.sequence_req = h.sequence_req + $urandom_range(1, 32'hFFFF_FFFE);
			8: h = mk_hdr(TYPE_AUDIO, 8'd0, g_sess, g_seq,
				g_audio ^ (32'd1 << $urandom_range(0, 31)), {16'd0, len_audio});
			9: begin
				// stale frame time, or a continuation with no frame open
				if (g_frame_on)
					h = mk_hdr(TYPE_VIDEO, 8'd0, g_sess, g_seq,
						$urandom_range(0, g_frame_ts), 32'd1);
				else
					h = mk_hdr(TYPE_VIDEO, FLAG_CONTINUES, g_sess, g_seq, $urandom, 32'd1);
			end
			10: h = mk_hdr($urandom_range(0, 1) ? TYPE_HELLO : TYPE_CONFIG, 8'd0, g_sess,
				g_seq, $urandom, {16'd0, lim_ctrl});
			default: begin
				h.magic = $urandom;
				h.version = 8'($urandom);
				h.packet_type = 8'($urandom);
				h.reserved_high = 8'($urandom);
				h.flag_bits = 8'($urandom);
				h.session_id = $urandom;
				h.sequence_req = $urandom;
				h.timestamp_ms = $urandom;
				h.payload_length = $urandom;
			end
		endcase
		return h;
	endfunction

	// move the clean-stream view past a packet that will be accepted
	task automatic advance(hdr_t h);
		g_seq = g_seq + 32'd1;
		if (h.packet_type == TYPE_AUDIO)
			g_audio = h.timestamp_ms + {22'd0, audio_step};
		if (h.packet_type == TYPE_VIDEO && (h.flag_bits & FLAG_CONTINUES) == 8'd0) begin
			g_frame_on = 1'b1;
			g_frame_ts = h.timestamp_ms;
		end
	endtask

	task automatic send_clean(hdr_t h);
		header_q.push_back(h);
		advance(h);
	endtask

	// wait until every header is taken and every verdict has come back
	task automatic drain();
		do @(negedge clk); while (header_q.size() != 0 || verdict_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		n_writes++;
		case (idx)
			REG_CONTROL_MAX: lim_ctrl = val[15:0];
			REG_AUDIO_BYTES: len_audio = val[15:0];
			REG_PALETTE_BYTES: len_palette = val[15:0];
			REG_VIDEO_MAX: lim_video = val;
			REG_AUDIO_STEP: audio_step = val[9:0];
			default: ;
		endcase
	endtask

	// mostly clean traffic with a quarter of broken packets mixed in
	task automatic run_phase(int unsigned n, bit long_hold, bit mid_pause);
		@(negedge clk);
		if (long_hold)
			hold_req++;
		for (int unsigned i = 0; i < n; i++) begin
			if (mid_pause && i == n / 2)
				drain();
			if ($urandom_range(0, 3) == 0)
				header_q.push_back(corrupt(next_legal()));
			else
				send_clean(next_legal());
		end
		drain();
	endtask

	// sender: bursts of random length with random gaps
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				verdict_q.push_back(judge_header(header_q.pop_front()));
				n_words++;
			end
			// a word on offer stays until taken
			if (!(s_tvalid && !s_tready)) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (header_q.size() == 0) begin
					s_tvalid <= 1'b0;
				end else begin
					s_tvalid <= 1'b1;
					s_tdata <= header_q[0];
					if (burst_left <= 1) begin
						burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 30);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// receiver: ready pattern that changes mode, plus requested long holds
	int unsigned tick = 0;
	int unsigned rdy_mode = 0;
	int unsigned hold_done = 0;
	int unsigned hold_left = 0;

	always @(posedge clk) begin : result_check
		res_t got;
		res_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = res_t'(m_tdata[2:0]);
				n_results++;
				if (got.status <= STATUS_REFUSED)
					status_cnt[got.status]++;
				if (verdict_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS)
						$display("result word %0d with nothing expected: status %0d ended %0b",
							n_results, got.status, got.stream_ended);
				end else begin
					want = verdict_q.pop_front();
					if (got.status != want.status || got.stream_ended !== want.stream_ended) begin
						err_cnt++;
						if (err_cnt <= MAX_REPORTS)
							$display("result word %0d: expected status %0d ended %0b, got status %0d ended %0b",
								n_results, want.status, want.stream_ended,
								got.status, got.stream_ended);
					end
				end
			end

			tick++;
			if (tick % 64 == 0)
				rdy_mode = $urandom_range(0, 3);
			if (hold_done != hold_req) begin
				hold_done++;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (rdy_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 9) != 0);
					default: m_tready <= (tick % 3 != 0);
				endcase
			end
		end
	end

	// watchdog on cycles with no handshake anywhere
	int unsigned idle_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("no handshake for %0d cycles, giving up", IDLE_LIMIT);
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		hdr_t h;
		hdr_t base;
		g_sess = $urandom | 32'd1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// before the stream is bound: broken headers and refused openers
		base = mk_hdr(TYPE_CONFIG, 8'd0, g_sess, 32'd0, 32'd0, 32'd64);
		h = base; h.magic = MAGIC_FAV1 ^ 32'h8000_0000; header_q.push_back(h);
		h = base; h.version = 8'hFF; header_q.push_back(h);
		h = base; h.reserved_high = 8'h80; header_q.push_back(h);
		header_q.push_back(mk_hdr(8'd0, 8'd0, g_sess, 32'd0, 32'd0, 32'd16));
		header_q.push_back(mk_hdr(8'hFF, 8'd0, g_sess, 32'd0, 32'd0, 32'd16));
		header_q.push_back(mk_hdr(TYPE_HELLO, 8'd0, g_sess, 32'd0, 32'd0, 32'd1));
		header_q.push_back(mk_hdr(TYPE_CONFIG, 8'd0, 32'd0, 32'd0, 32'd0, 32'd16));
		header_q.push_back(mk_hdr(TYPE_CONFIG, 8'd0, g_sess, 32'd1, 32'd0, 32'd16));
		header_q.push_back(mk_hdr(TYPE_CONFIG, 8'd0, g_sess, 32'd0, 32'd5, 32'd16));
		header_q.push_back(mk_hdr(TYPE_END, 8'd0, g_sess, 32'd0, 32'd0, 32'd0));
		header_q.push_back(mk_hdr(TYPE_ERROR, 8'd0, g_sess, 32'd0, 32'd0, {16'd0, lim_ctrl}));
		header_q.push_back(mk_hdr(TYPE_CONFIG, FLAG_CONTINUES, g_sess, 32'd0, 32'd0, 32'd16));
		header_q.push_back(mk_hdr(TYPE_CONFIG, 8'd0, g_sess, 32'd0, 32'd0, 32'd0));
		header_q.push_back(mk_hdr(TYPE_CONFIG, 8'd0, g_sess, 32'd0, 32'd0, lim_ctrl + 32'd1));
		send_clean(mk_hdr(TYPE_CONFIG, 8'd0, g_sess, 32'd0, 32'd0, {16'd0, lim_ctrl}));

		// bound stream: late openers, orphan continuation, overflow and wrap
		header_q.push_back(mk_hdr(TYPE_HELLO, 8'd0, g_sess, g_seq, 32'd0, 32'd1));
		header_q.push_back(mk_hdr(TYPE_CONFIG, 8'd0, g_sess, g_seq, 32'd0, 32'd1));
		header_q.push_back(mk_hdr(TYPE_VIDEO, FLAG_CONTINUES, g_sess, g_seq, 32'd0, 32'd1));
		header_q.push_back(mk_hdr(TYPE_AUDIO, 8'd0, g_sess, g_seq, ALL_ONES_32 - 32'd5,
			{16'd0, len_audio}));
		header_q.push_back(mk_hdr(TYPE_PALETTE, 8'd0, g_sess, ALL_ONES_32, 32'd0,
			{16'd0, len_palette}));
		send_clean(mk_hdr(TYPE_AUDIO, 8'd0, g_sess, g_seq, g_audio, {16'd0, len_audio}));
		send_clean(mk_hdr(TYPE_VIDEO, 8'd0, g_sess, g_seq, 32'd1000, {8'd0, lim_video}));
		send_clean(mk_hdr(TYPE_VIDEO, FLAG_CONTINUES, g_sess, g_seq, 32'd7, 32'd1));
		header_q.push_back(mk_hdr(TYPE_VIDEO, 8'd0, g_sess, g_seq, 32'd1000, 32'd1));
		send_clean(mk_hdr(TYPE_PALETTE, 8'd0, g_sess, g_seq, $urandom, {16'd0, len_palette}));
		header_q.push_back(mk_hdr(TYPE_VIDEO, 8'd0, g_sess, g_seq, 32'd2000, 32'd0));
		header_q.push_back(mk_hdr(TYPE_VIDEO, 8'h02, g_sess, g_seq, 32'd2000, 32'd1));
		drain();

		// smallest register values
		write_reg(REG_CONTROL_MAX, 24'd1);
		write_reg(REG_AUDIO_BYTES, 24'd1);
		write_reg(REG_PALETTE_BYTES, 24'd1);
		write_reg(REG_VIDEO_MAX, 24'd1);
		write_reg(REG_AUDIO_STEP, 24'd1);
		run_phase(100, 1'b1, 1'b0);

		// largest register values, with the audio step at 1000
		write_reg(REG_CONTROL_MAX, 24'h00FFFF);
		write_reg(REG_AUDIO_BYTES, 24'h00FFFF);
		write_reg(REG_PALETTE_BYTES, 24'h00FFFF);
		write_reg(REG_VIDEO_MAX, 24'hFFFFFF);
		write_reg(REG_AUDIO_STEP, 24'd1000);
		run_phase(100, 1'b0, 1'b1);

		// zero after truncation to register width, and a write to no register
		write_reg(REG_CONTROL_MAX, 24'h010000);
		write_reg(REG_AUDIO_BYTES, 24'hFF0000);
		write_reg(REG_PALETTE_BYTES, 24'h000000);
		write_reg(REG_AUDIO_STEP, 24'hFFFC00);
		write_reg(REG_VIDEO_MAX, 24'($urandom_range(1, 24'hFFFFFF)));
		write_reg(REG_UNUSED, 24'h5A5A5A);
		run_phase(100, 1'b0, 1'b0);

		// random settings
		for (int p = 0; p < 3; p++) begin
			write_reg(REG_CONTROL_MAX, 24'($urandom_range(1, 16'hFFFF)));
			write_reg(REG_AUDIO_BYTES, 24'($urandom_range(1, 16'hFFFF)));
			write_reg(REG_PALETTE_BYTES, 24'($urandom_range(1, 16'hFFFF)));
			write_reg(REG_VIDEO_MAX, 24'($urandom_range(1, 24'hFFFFFF)));
			write_reg(REG_AUDIO_STEP, 24'($urandom_range(1, 1000)));
			run_phase(100, p == 1, p == 2);
		end

		// back to defaults, then close the stream and poke at it
		write_reg(REG_CONTROL_MAX, {8'd0, RST_CONTROL_MAX});
		write_reg(REG_AUDIO_BYTES, {8'd0, RST_AUDIO_BYTES});
		write_reg(REG_PALETTE_BYTES, {8'd0, RST_PALETTE_BYTES});
		write_reg(REG_VIDEO_MAX, RST_VIDEO_MAX);
		write_reg(REG_AUDIO_STEP, {14'd0, RST_AUDIO_STEP});
		@(negedge clk);
		if ($urandom_range(0, 1))
			send_clean(mk_hdr(TYPE_END, 8'd0, g_sess, g_seq, $urandom, 32'd0));
		else
			send_clean(mk_hdr(TYPE_ERROR, 8'd0, g_sess, g_seq, $urandom,
				$urandom_range(1, lim_ctrl)));
		header_q.push_back(next_legal());
		header_q.push_back(mk_hdr(TYPE_ERROR, 8'd0, g_sess, g_seq, 32'd0, 32'd1));
		header_q.push_back(mk_hdr(TYPE_END, 8'd0, g_sess, g_seq, 32'd0, 32'd0));
		for (int i = 0; i < 8; i++)
			header_q.push_back(corrupt(next_legal()));
		drain();
		repeat (8) @(negedge clk);

		$display("sent %0d headers and %0d register writes; checked %0d results",
			n_words, n_writes, n_results);
		$display("verdicts seen: %0d accepted, %0d malformed, %0d refused",
			status_cnt[STATUS_OK], status_cnt[STATUS_MALFORMED], status_cnt[STATUS_REFUSED]);
		if (err_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatching results", err_cnt);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
